// ----- rtl/core/dehp_pkg.sv -----
// shared types and constants of the dicom element header parser
`timescale 1ns / 1ps
`default_nettype none

package dehp_pkg;

    // transfer syntax codes
    localparam logic [1:0] MODE_EXPL_LE = 2'd0;
    localparam logic [1:0] MODE_IMPL_LE = 2'd1;
    localparam logic [1:0] MODE_EXPL_BE = 2'd2;

    // configuration register index, taken from paddr[2]
    localparam logic REG_SYNTAX_MODE = 1'b0;
    localparam int unsigned PADDR_W = 3;

    // result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_VALUE  = 1'b1;

    localparam logic [31:0] LEN_UNDEFINED = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        item_kind;
        logic [15:0] tag_group;
        logic [15:0] tag_element;
        logic [15:0] vr_code;
        logic [31:0] value_length;
        logic        undefined_length;
        logic [7:0]  value_byte;
        logic        last_value;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/dehp_ifs.sv -----
// byte input and result output channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface dehp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface dehp_result_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [15:0] tag_group;
    logic [15:0] tag_element;
    logic [15:0] vr_code;
    logic [31:0] value_length;
    logic        undefined_length;
    logic [7:0]  value_byte;
    logic        last_value;

    modport source (
        output valid, input ready,
        output item_kind, output tag_group, output tag_element, output vr_code,
        output value_length, output undefined_length, output value_byte,
        output last_value
    );
    modport sink (
        input valid, output ready,
        input item_kind, input tag_group, input tag_element, input vr_code,
        input value_length, input undefined_length, input value_byte,
        input last_value
    );
endinterface

`default_nettype wire

// ----- rtl/core/dehp_parse_core.sv -----
// element header state machine and field assembly, one byte per accepted word
`timescale 1ns / 1ps
`default_nettype none

module dehp_parse_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      in_byte,
    input  wire logic [1:0]      syntax_mode,
    output logic                 res_valid,
    output dehp_pkg::result_t    res
);
    import dehp_pkg::*;

    localparam logic [3:0] PH_GROUP0  = 4'd0;
    localparam logic [3:0] PH_GROUP1  = 4'd1;
    localparam logic [3:0] PH_ELEM0   = 4'd2;
    localparam logic [3:0] PH_ELEM1   = 4'd3;
    localparam logic [3:0] PH_VR0     = 4'd4;
    localparam logic [3:0] PH_VR1     = 4'd5;
    localparam logic [3:0] PH_RSVD0   = 4'd6;
    localparam logic [3:0] PH_RSVD1   = 4'd7;
    localparam logic [3:0] PH_LLEN0   = 4'd8;
    localparam logic [3:0] PH_LLEN1   = 4'd9;
    localparam logic [3:0] PH_LLEN2   = 4'd10;
    localparam logic [3:0] PH_LLEN3   = 4'd11;
    localparam logic [3:0] PH_SLEN0   = 4'd12;
    localparam logic [3:0] PH_SLEN1   = 4'd13;
    localparam logic [3:0] PH_VALUE   = 4'd14;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] group_reg, group_next;
    logic [15:0] element_reg, element_next;
    logic [15:0] vr_reg, vr_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] remain_reg, remain_next;

    logic        big;
    logic        implicit_mode;
    logic [15:0] vr_full;
    logic [31:0] len_full;
    logic        is_long;
    logic        undef;
    logic        last;

    function automatic logic [15:0] shift16(input logic [15:0] r, input logic [7:0] b,
                                            input logic be);
        if (be)
            return {r[7:0], b};
        return {b, r[15:8]};
    endfunction

    function automatic logic [31:0] shift32(input logic [31:0] r, input logic [7:0] b,
                                            input logic be);
        if (be)
            return {r[23:0], b};
        return {b, r[31:8]};
    endfunction

    always_comb
    begin
        big           = (syntax_mode == MODE_EXPL_BE);
        implicit_mode = (syntax_mode == MODE_IMPL_LE);
        vr_full       = {vr_reg[7:0], in_byte};
        is_long       = (vr_full inside {16'h4F42, 16'h4F57, 16'h4F46,
                                         16'h5351, 16'h5554, 16'h554E});
        if (phase_reg == PH_SLEN1)
            len_full = big ? {16'h0, length_reg[7:0], in_byte}
                           : {16'h0, in_byte, length_reg[7:0]};
        else
            len_full = shift32(length_reg, in_byte, big);
        undef = (len_full == LEN_UNDEFINED);
        last  = (remain_reg <= 32'd1);

        phase_next   = phase_reg;
        group_next   = group_reg;
        element_next = element_reg;
        vr_next      = vr_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        res_valid    = 1'b0;

        res.item_kind        = KIND_HEADER;
        res.tag_group        = group_reg;
        res.tag_element      = element_reg;
        res.vr_code          = vr_reg;
        res.value_length     = len_full;
        res.undefined_length = undef;
        res.value_byte       = 8'h00;
        res.last_value       = 1'b0;

        case (phase_reg)
            PH_GROUP0, PH_GROUP1:
            begin
                group_next = shift16(group_reg, in_byte, big);
                phase_next = phase_reg + 4'd1;
            end
            PH_ELEM0:
            begin
                element_next = shift16(element_reg, in_byte, big);
                phase_next   = PH_ELEM1;
            end
            PH_ELEM1:
            begin
                element_next = shift16(element_reg, in_byte, big);
                if (implicit_mode)
                begin
                    vr_next    = 16'h0;
                    phase_next = PH_LLEN0;
                end
                else
                begin
                    phase_next = PH_VR0;
                end
            end
            PH_VR0:
            begin
                vr_next    = {8'h00, in_byte};
                phase_next = PH_VR1;
            end
            PH_VR1:
            begin
                vr_next    = vr_full;
                phase_next = is_long ? PH_RSVD0 : PH_SLEN0;
            end
            PH_RSVD0, PH_RSVD1, PH_LLEN0, PH_LLEN1, PH_LLEN2:
            begin
                // reserved bytes are dropped, length bytes shift in
                if (phase_reg >= PH_LLEN0)
                    length_next = len_full;
                phase_next = phase_reg + 4'd1;
            end
            PH_SLEN0:
            begin
                length_next = {24'h0, in_byte};
                phase_next  = PH_SLEN1;
            end
            PH_LLEN3, PH_SLEN1:
            begin
                length_next = len_full;
                res_valid   = 1'b1;
                if (undef || len_full == 32'h0)
                begin
                    phase_next = PH_GROUP0;
                end
                else
                begin
                    remain_next = len_full;
                    phase_next  = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                res_valid            = 1'b1;
                res.item_kind        = KIND_VALUE;
                res.value_length     = length_reg;
                res.undefined_length = 1'b0;
                res.value_byte       = in_byte;
                res.last_value       = last;
                if (last)
                begin
                    remain_next = 32'h0;
                    phase_next  = PH_GROUP0;
                end
                else
                begin
                    remain_next = remain_reg - 32'd1;
                end
            end
            default:
            begin
                phase_next = PH_GROUP0;
            end
        endcase

        if (!accept)
            res_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_GROUP0;
            group_reg   <= 16'h0;
            element_reg <= 16'h0;
            vr_reg      <= 16'h0;
            length_reg  <= 32'h0;
            remain_reg  <= 32'h0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            group_reg   <= group_next;
            element_reg <= element_next;
            vr_reg      <= vr_next;
            length_reg  <= length_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dehp_out_stage.sv -----
// result register between the parser and the output channel
`timescale 1ns / 1ps
`default_nettype none

module dehp_out_stage
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire dehp_pkg::result_t  res,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output dehp_pkg::result_t       out_res,
    output logic                    space
);
    import dehp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign space = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dicom_element_header_parser.sv -----
// dicom element header parser top level
`timescale 1ns / 1ps
`default_nettype none

// Takes one data set byte per cycle on the stream channel and returns, on the
// result channel, one header word per element (tag, vr, length) followed by one
// word per value byte, the last one marked. A header word appears in the cycle
// after the final length byte is taken; a value word in the cycle after its byte.
// Throughput is one byte per cycle, set by the single result register: stream
// ready stays high while that register is empty or being read. syntax_mode sits
// at byte address 0 of the apb port (0 explicit le, 1 implicit le, 2 explicit be,
// 3 acts as explicit le); write it only while the block is idle (not enforced).

module dicom_element_header_parser
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    dehp_byte_if.sink                             stream,
    dehp_result_if.source                         result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dehp_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import dehp_pkg::*;

    logic       mode_hit;
    logic [1:0] syntax_mode_reg;
    logic       accept;
    logic       space;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign pready = 1'b1;
    assign mode_hit = (paddr[2] == REG_SYNTAX_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            syntax_mode_reg <= MODE_EXPL_LE;
        else if (psel && penable && pwrite && mode_hit)
            syntax_mode_reg <= pwdata[1:0];
    end

    assign prdata = mode_hit ? {30'h0, syntax_mode_reg} : 32'h0;

    assign stream.ready = space;
    assign accept       = stream.valid && space;

    dehp_parse_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (stream.in_byte),
        .syntax_mode (syntax_mode_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    dehp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_res   (out_res),
        .space     (space)
    );

    assign result.item_kind        = out_res.item_kind;
    assign result.tag_group        = out_res.tag_group;
    assign result.tag_element      = out_res.tag_element;
    assign result.vr_code          = out_res.vr_code;
    assign result.value_length     = out_res.value_length;
    assign result.undefined_length = out_res.undefined_length;
    assign result.value_byte       = out_res.value_byte;
    assign result.last_value       = out_res.last_value;

endmodule

`default_nettype wire

// ----- rtl/core/dehp_checker.sv -----
// port level checks for the dicom element header parser
`timescale 1ns / 1ps
`default_nettype none

module dehp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        item_kind,
    input wire logic [31:0] value_length,
    input wire logic        undefined_length,
    input wire logic        last_value
);
    import dehp_pkg::*;

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // new results only follow an accepted byte
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result word without an accepted byte");

    // empty result register always takes a byte
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("stream stalled with empty result register");

    a_undef_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && undefined_length |->
            item_kind == KIND_HEADER && value_length == LEN_UNDEFINED)
        else $error("undefined length on a bad word");

    a_last_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_value |-> item_kind == KIND_VALUE)
        else $error("last marker on a header word");

endmodule

bind dicom_element_header_parser dehp_checker u_dehp_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (stream.valid),
    .in_ready         (stream.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .item_kind        (result.item_kind),
    .value_length     (result.value_length),
    .undefined_length (result.undefined_length),
    .last_value       (result.last_value)
);

`default_nettype wire

// ----- test/tb.sv -----
// testbench of the dicom element header parser: byte stream stimulus, predicted result words
`timescale 1ns / 1ps

module tb;
    import dehp_pkg::*;

    localparam logic [1:0] MODE_RSVD = 2'd3;
    localparam logic [15:0] VR_OB = "OB";
    localparam logic [15:0] VR_OW = "OW";
    localparam logic [15:0] VR_OF = "OF";
    localparam logic [15:0] VR_SQ = "SQ";
    localparam logic [15:0] VR_UT = "UT";
    localparam logic [15:0] VR_UN = "UN";
    localparam int NUM_PHASES = 7;
    localparam int RANDOM_PER_PHASE = 35;
    localparam int NOISE_BYTES = 40;
    localparam int PN_CUT = 24;
    localparam int DRAIN_GAP = 4;
    localparam int HOLD_AT = 100;
    localparam int HOLD_LEN = 300;
    localparam int CALM_FROM = 500;
    localparam int CALM_TO = 900;
    localparam int MAX_PRINTS = 40;

    typedef enum logic [3:0] {
        PH_GRP0, PH_GRP1, PH_ELM0, PH_ELM1, PH_VR0, PH_VR1, PH_RSV0, PH_RSV1,
        PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3, PH_SLEN0, PH_SLEN1, PH_VALUE
    } parse_phase_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic [7:0] in_data = 8'h00;
    logic       out_ready = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    dehp_byte_if   byte_ch ();
    dehp_result_if res_ch ();

    assign byte_ch.valid = in_valid;
    assign byte_ch.in_byte = in_data;
    assign res_ch.ready = out_ready;

    dicom_element_header_parser dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (byte_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser state mirrored by the predictor
    logic [1:0]   mode_cfg = MODE_EXPL_LE;
    parse_phase_e ph = PH_GRP0;
    logic [15:0]  grp_acc = '0;
    logic [15:0]  elm_acc = '0;
    logic [15:0]  vr_acc = '0;
    logic [31:0]  len_acc = '0;
    logic [31:0]  remain = '0;
    logic         long_len = 1'b0;

    logic [7:0] stream_bytes [$];
    result_t    parsed_words [$];
    result_t    want_word;
    int         queued_total = 0;
    int         fail_count = 0;
    int         cycle_cnt = 0;
    int         hold_left = 0;
    logic       calm;
    logic [15:0] long_vrs [6] = '{VR_OB, VR_OW, VR_OF, VR_SQ, VR_UT, VR_UN};

    assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // long receiver hold-off so the block backs up into the stream side
    always @(posedge clk)
    begin
        if (cycle_cnt == HOLD_AT)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < MAX_PRINTS)
            $display("mismatch at %0d: %s got %h expected %h", cycle_cnt, what, got, want);
        fail_count++;
    endtask

    function automatic logic [15:0] shift_in16(input logic [15:0] acc, input logic [7:0] b,
                                               input logic big);
        return big ? {acc[7:0], b} : {b, acc[15:8]};
    endfunction

    function automatic logic [31:0] shift_in32(input logic [31:0] acc, input logic [7:0] b,
                                               input logic big);
        return big ? {acc[23:0], b} : {b, acc[31:8]};
    endfunction

    function automatic logic vr_has_long_length(input logic [15:0] vr);
        return vr inside {VR_OB, VR_OW, VR_OF, VR_SQ, VR_UT, VR_UN};
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        logic implicit_syn;
        logic big;
        logic hdr_done;
        result_t w;
        implicit_syn = (mode_cfg == MODE_IMPL_LE);
        big = (mode_cfg == MODE_EXPL_BE);
        hdr_done = 1'b0;
        w = '0;
        case (ph)
            PH_GRP0:
            begin
                grp_acc = shift_in16(grp_acc, b, big);
                ph = PH_GRP1;
            end
            PH_GRP1:
            begin
                grp_acc = shift_in16(grp_acc, b, big);
                ph = PH_ELM0;
            end
            PH_ELM0:
            begin
                elm_acc = shift_in16(elm_acc, b, big);
                ph = PH_ELM1;
            end
            PH_ELM1:
            begin
                elm_acc = shift_in16(elm_acc, b, big);
                if (implicit_syn)
                begin
                    vr_acc = '0;
                    long_len = 1'b1;
                    ph = PH_LEN0;
                end
                else
                    ph = PH_VR0;
            end
            PH_VR0:
            begin
                vr_acc = {8'h00, b};
                ph = PH_VR1;
            end
            PH_VR1:
            begin
                vr_acc = {vr_acc[7:0], b};
                long_len = vr_has_long_length(vr_acc);
                ph = long_len ? PH_RSV0 : PH_SLEN0;
            end
            PH_RSV0: ph = PH_RSV1;
            PH_RSV1: ph = PH_LEN0;
            PH_LEN0:
            begin
                len_acc = shift_in32(len_acc, b, big);
                ph = PH_LEN1;
            end
            PH_LEN1:
            begin
                len_acc = shift_in32(len_acc, b, big);
                ph = PH_LEN2;
            end
            PH_LEN2:
            begin
                len_acc = shift_in32(len_acc, b, big);
                ph = PH_LEN3;
            end
            PH_LEN3:
            begin
                len_acc = shift_in32(len_acc, b, big);
                hdr_done = 1'b1;
            end
            PH_SLEN0:
            begin
                len_acc = {24'h0, b};
                ph = PH_SLEN1;
            end
            PH_SLEN1:
            begin
                len_acc = big ? {16'h0, len_acc[7:0], b} : {16'h0, b, len_acc[7:0]};
                hdr_done = 1'b1;
            end
            PH_VALUE:
            begin
                w.item_kind = KIND_VALUE;
                w.tag_group = grp_acc;
                w.tag_element = elm_acc;
                w.vr_code = vr_acc;
                w.value_length = len_acc;
                w.value_byte = b;
                w.last_value = (remain <= 32'd1);
                parsed_words.push_back(w);
                if (w.last_value)
                begin
                    remain = '0;
                    ph = PH_GRP0;
                end
                else
                    remain = remain - 32'd1;
            end
            default: ph = PH_GRP0;
        endcase
        if (hdr_done)
        begin
            w.item_kind = KIND_HEADER;
            w.tag_group = grp_acc;
            w.tag_element = elm_acc;
            w.vr_code = vr_acc;
            w.value_length = len_acc;
            w.undefined_length = (len_acc == LEN_UNDEFINED);
            parsed_words.push_back(w);
            if (w.undefined_length || len_acc == '0)
                ph = PH_GRP0;
            else
            begin
                remain = len_acc;
                ph = PH_VALUE;
            end
        end
    endtask

    // stream driver: one byte per handshake, random gaps outside the calm window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= 8'h00;
        end
        else
        begin
            if (in_valid && byte_ch.ready)
                parse_byte(in_data);
            if (!in_valid || byte_ch.ready)
            begin
                if (stream_bytes.size() != 0 && (calm || $urandom_range(99) >= 33))
                begin
                    in_valid <= 1'b1;
                    in_data <= stream_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (res_ch.valid && out_ready)
            begin
                if (parsed_words.size() == 0)
                    report_mismatch("unexpected result word", {16'h0, res_ch.tag_group}, '0);
                else
                begin
                    want_word = parsed_words.pop_front();
                    if (res_ch.item_kind !== want_word.item_kind)
                        report_mismatch("item_kind", 32'(res_ch.item_kind),
                                        32'(want_word.item_kind));
                    if (res_ch.tag_group !== want_word.tag_group)
                        report_mismatch("tag_group", 32'(res_ch.tag_group),
                                        32'(want_word.tag_group));
                    if (res_ch.tag_element !== want_word.tag_element)
                        report_mismatch("tag_element", 32'(res_ch.tag_element),
                                        32'(want_word.tag_element));
                    if (res_ch.vr_code !== want_word.vr_code)
                        report_mismatch("vr_code", 32'(res_ch.vr_code),
                                        32'(want_word.vr_code));
                    if (res_ch.value_length !== want_word.value_length)
                        report_mismatch("value_length", res_ch.value_length,
                                        want_word.value_length);
                    if (res_ch.undefined_length !== want_word.undefined_length)
                        report_mismatch("undefined_length", 32'(res_ch.undefined_length),
                                        32'(want_word.undefined_length));
                    if (res_ch.value_byte !== want_word.value_byte)
                        report_mismatch("value_byte", 32'(res_ch.value_byte),
                                        32'(want_word.value_byte));
                    if (res_ch.last_value !== want_word.last_value)
                        report_mismatch("last_value", 32'(res_ch.last_value),
                                        32'(want_word.last_value));
                end
            end
            out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 33);
        end
    end

    // lays out one element under the given syntax and queues bytes [from, upto)
    task automatic send_element(input logic [1:0] m, input logic [15:0] grp,
                                input logic [15:0] elm, input logic [15:0] vr,
                                input logic [31:0] len, input int from, input int upto);
        logic [7:0] b [$];
        logic big;
        logic impl;
        logic lf;
        int n_val;
        int stop;
        big = (m == MODE_EXPL_BE);
        impl = (m == MODE_IMPL_LE);
        lf = impl || vr_has_long_length(vr);
        b.push_back(big ? grp[15:8] : grp[7:0]);
        b.push_back(big ? grp[7:0] : grp[15:8]);
        b.push_back(big ? elm[15:8] : elm[7:0]);
        b.push_back(big ? elm[7:0] : elm[15:8]);
        if (!impl)
        begin
            b.push_back(vr[15:8]);
            b.push_back(vr[7:0]);
            if (lf)
            begin
                // reserved bytes carry junk, the parser ignores them
                b.push_back(8'($urandom));
                b.push_back(8'($urandom));
            end
        end
        if (lf)
        begin
            for (int i = 0; i < 4; i++)
                b.push_back(big ? len[8*(3-i) +: 8] : len[8*i +: 8]);
            n_val = (len == LEN_UNDEFINED) ? 0 : int'(len);
        end
        else
        begin
            b.push_back(big ? len[15:8] : len[7:0]);
            b.push_back(big ? len[7:0] : len[15:8]);
            n_val = int'(len[15:0]);
        end
        repeat (n_val) b.push_back(8'($urandom));
        stop = (upto < 0 || upto > b.size()) ? b.size() : upto;
        for (int i = from; i < stop; i++)
            stream_bytes.push_back(b[i]);
        queued_total += stop - from;
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (stream_bytes.size() != 0 || in_valid);
        while (parsed_words.size() != 0) @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic set_syntax_mode(input logic [1:0] m);
        logic [31:0] rd;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_SYNTAX_MODE, 2'b00};
        pwdata <= {30'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        mode_cfg = m;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== {30'd0, m})
            report_mismatch("syntax_mode readback", rd, {30'd0, m});
    endtask

    initial
    begin
        logic [1:0] phase_modes [NUM_PHASES];
        logic [1:0] m;
        logic [15:0] grp;
        logic [15:0] elm;
        logic [15:0] vr;
        logic [31:0] len;
        logic lf;
        int r;
        int target;
        logic [15:0] carry_grp;
        logic [15:0] carry_elm;
        logic [15:0] carry_vr;
        logic [31:0] carry_len;

        phase_modes = '{MODE_EXPL_LE, MODE_IMPL_LE, MODE_EXPL_BE, MODE_RSVD,
                        MODE_IMPL_LE, MODE_EXPL_BE, MODE_EXPL_LE};
        carry_grp = '0;
        carry_elm = '0;
        carry_vr = VR_OB;
        carry_len = 32'd1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            m = phase_modes[p];
            wait_idle();
            set_syntax_mode(m);

            // finish the element whose tag began under the previous mode
            if (p > 0)
                send_element(m, carry_grp, carry_elm, carry_vr, carry_len, 2, -1);

            send_element(m, 16'hFFFF, 16'hFFFF, VR_SQ, LEN_UNDEFINED, 0, -1);
            send_element(m, 16'h0000, 16'h0000, VR_UN, 32'd0, 0, -1);
            send_element(m, 16'h7FE0, 16'h0010, VR_OB, 32'd1, 0, -1);
            if (p == 0)
            begin
                send_element(m, 16'h0002, 16'h0001, VR_OW, 32'd4, 0, -1);
                send_element(m, 16'h0028, 16'h3006, VR_OF, 32'd4, 0, -1);
                send_element(m, 16'h0018, 16'h9219, VR_UT, 32'd3, 0, -1);
                send_element(m, 16'h0008, 16'h0060, "CS", 32'd2, 0, -1);
                send_element(m, 16'h0008, 16'h0016, "UI", 32'd0, 0, -1);
                send_element(m, 16'h0020, 16'h000D, "US", 32'd2, 0, -1);
            end

            target = queued_total + RANDOM_PER_PHASE;
            while (queued_total < target)
            begin
                r = $urandom_range(99);
                grp = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
                r = $urandom_range(99);
                elm = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
                r = $urandom_range(99);
                if (r < 45)
                    vr = long_vrs[$urandom_range(5)];
                else if (r < 85)
                    vr = {8'h41 + 8'($urandom_range(25)), 8'h41 + 8'($urandom_range(25))};
                else
                    vr = 16'($urandom);
                lf = (m == MODE_IMPL_LE) || vr_has_long_length(vr);
                r = $urandom_range(99);
                if (r < 8)
                    len = 32'd0;
                else if (r < 16)
                    len = lf ? LEN_UNDEFINED : 32'd0;
                else if (r < 22)
                    len = $urandom_range(40, 9);
                else
                    len = $urandom_range(8, 1);
                send_element(m, grp, elm, vr, len, 0, -1);
            end

            if (p == NUM_PHASES - 1)
            begin
                // short length of all ones is an ordinary length; the element is
                // cut short and the raw tail bytes pass as its value
                send_element(m, 16'h0010, 16'h0010, "PN", 32'h0000_FFFF, 0, PN_CUT);
                repeat (NOISE_BYTES) stream_bytes.push_back(8'($urandom));
                queued_total += NOISE_BYTES;
            end
            else
            begin
                carry_grp = 16'($urandom);
                carry_elm = 16'($urandom);
                carry_vr = long_vrs[$urandom_range(5)];
                carry_len = $urandom_range(4, 1);
                send_element(m, carry_grp, carry_elm, carry_vr, carry_len, 0, 2);
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
